[design/date_period_overlap_days_assert.svh]
// assertion macros used by the checker file
`ifndef DATE_PERIOD_OVERLAP_DAYS_ASSERT_SVH
`define DATE_PERIOD_OVERLAP_DAYS_ASSERT_SVH

// same-cycle implication, off during reset
`define DPOD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpod assertion failed");

// next-cycle implication, off during reset
`define DPOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpod assertion failed");

`endif

[design/dpod_pkg.sv]
// types and constants for the date period overlap pipeline
package dpod_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DN_W    = 23;  // day number of years up to 16383
  localparam int DAYS_W  = 22;
  localparam int C100_W  = 8;   // ceil(year / 100)
  localparam int NUM_STAGES = 5;

  localparam logic [DAYS_W-1:0] DAYS_MAX = 22'h3FFFFF;

  // reciprocal for floor(x / 100), exact for x below 43690
  localparam int RECIP_100_SHIFT = 21;
  localparam logic [14:0] RECIP_100 = 15'd20972;

  localparam logic [MONTH_W-1:0] MARCH = 4'd3;

  // days before each month code, codes above twelve add the full year
  localparam logic [8:0] CUM_DAYS [16] = '{
    9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // after the multiply stage
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DN_W-1:0]    y365;
    logic [C100_W-1:0]  c100;
  } dn_part_t;

  // after the year-base stage
  typedef struct packed {
    logic [DN_W-1:0]    base;
    logic               leap;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } dn_base_t;

endpackage

[design/date_period_overlap_days.sv]
// Date period overlap day counter. Each request carries two periods (start and
// end year, month, day) and returns whether they share a date and the day count
// from the later start to the earlier end, last day not counted. The block is a
// five-stage pipeline: date compare and select, year multiply, year base and
// leap test, month and day add, subtract and clamp. It takes one request per
// clock while in_stall is low. Each stage moves on when the stage after it is
// empty or moving, so a stalled output still lets requests fill empty stages;
// in_stall rises only when all five stages hold work and out_stall is high.
module date_period_overlap_days (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dpod_pkg::YEAR_W-1:0]   in_first_start_year,
  input  logic [dpod_pkg::MONTH_W-1:0]  in_first_start_month,
  input  logic [dpod_pkg::DAY_W-1:0]    in_first_start_day,
  input  logic [dpod_pkg::YEAR_W-1:0]   in_first_end_year,
  input  logic [dpod_pkg::MONTH_W-1:0]  in_first_end_month,
  input  logic [dpod_pkg::DAY_W-1:0]    in_first_end_day,
  input  logic [dpod_pkg::YEAR_W-1:0]   in_second_start_year,
  input  logic [dpod_pkg::MONTH_W-1:0]  in_second_start_month,
  input  logic [dpod_pkg::DAY_W-1:0]    in_second_start_day,
  input  logic [dpod_pkg::YEAR_W-1:0]   in_second_end_year,
  input  logic [dpod_pkg::MONTH_W-1:0]  in_second_end_month,
  input  logic [dpod_pkg::DAY_W-1:0]    in_second_end_day,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_periods_overlap,
  output logic [dpod_pkg::DAYS_W-1:0]   out_overlap_days
);
  import dpod_pkg::*;

  // lane 0 is the later start, lane 1 the earlier end
  logic [NUM_STAGES-1:0] v_r, v_nxt, adv;

  date_t    s1_date_r [2];
  date_t    s1_date_nxt [2];
  logic     s1_ov_r, s1_ov_nxt;
  dn_part_t s2_part_r [2];
  dn_part_t s2_part_nxt [2];
  logic     s2_ov_r;
  dn_base_t s3_base_r [2];
  dn_base_t s3_base_nxt [2];
  logic     s3_ov_r;
  logic [DN_W-1:0] s4_dn_r [2];
  logic [DN_W-1:0] s4_dn_nxt [2];
  logic     s4_ov_r;
  logic     out_periods_overlap_r, out_periods_overlap_nxt;
  logic [DAYS_W-1:0] out_overlap_days_r, out_overlap_days_nxt;

  date_t s1, e1, s2, e2;
  logic  e1_lt_s2, e2_lt_s1, s1_lt_s2, e1_lt_e2;

  // ready chain, from the output back to the input
  always_comb begin
    adv[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt[0] = adv[0] ? in_valid : v_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 1: date ordering on the packed year/month/day key
  always_comb begin
    s1 = '{year: in_first_start_year, month: in_first_start_month, day: in_first_start_day};
    e1 = '{year: in_first_end_year, month: in_first_end_month, day: in_first_end_day};
    s2 = '{year: in_second_start_year, month: in_second_start_month,
           day: in_second_start_day};
    e2 = '{year: in_second_end_year, month: in_second_end_month, day: in_second_end_day};
    e1_lt_s2 = e1 < s2;
    e2_lt_s1 = e2 < s1;
    s1_lt_s2 = s1 < s2;
    e1_lt_e2 = e1 < e2;
    s1_ov_nxt = !e1_lt_s2 && !e2_lt_s1;
    s1_date_nxt[0] = s1_lt_s2 ? s2 : s1;
    s1_date_nxt[1] = e1_lt_e2 ? e1 : e2;
  end

  // stage 2: 365 * year and ceil(year / 100) by reciprocal
  always_comb begin
    logic [YEAR_W:0] y99;
    logic [29:0]     prod;
    for (int i = 0; i < 2; i++) begin
      y99  = {1'b0, s1_date_r[i].year} + (YEAR_W+1)'(99);
      prod = 30'(y99) * 30'(RECIP_100);
      s2_part_nxt[i].year  = s1_date_r[i].year;
      s2_part_nxt[i].month = s1_date_r[i].month;
      s2_part_nxt[i].day   = s1_date_r[i].day;
      s2_part_nxt[i].y365  = DN_W'(s1_date_r[i].year) * DN_W'(365);
      s2_part_nxt[i].c100  = prod[RECIP_100_SHIFT +: C100_W];
    end
  end

  // stage 3: days of all earlier years and the leap test
  always_comb begin
    logic [YEAR_W-2:0] q4;
    logic [C100_W-3:0] c400;
    logic [YEAR_W:0]   mul100;
    for (int i = 0; i < 2; i++) begin
      q4     = (YEAR_W-1)'(({1'b0, s2_part_r[i].year} + (YEAR_W+1)'(3)) >> 2);
      c400   = (C100_W-2)'(({1'b0, s2_part_r[i].c100} + (C100_W+1)'(3)) >> 2);
      mul100 = (YEAR_W+1)'(s2_part_r[i].c100) * (YEAR_W+1)'(100);
      s3_base_nxt[i].base  = s2_part_r[i].y365 + DN_W'(q4) - DN_W'(s2_part_r[i].c100)
                           + DN_W'(c400);
      // divisible by 4, and either not by 100 or also by 400
      s3_base_nxt[i].leap  = (s2_part_r[i].year[1:0] == 2'b00) &&
                             ((mul100 != {1'b0, s2_part_r[i].year}) ||
                              (s2_part_r[i].c100[1:0] == 2'b00));
      s3_base_nxt[i].month = s2_part_r[i].month;
      s3_base_nxt[i].day   = s2_part_r[i].day;
    end
  end

  // stage 4: add month offset, leap day and day of month
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s4_dn_nxt[i] = s3_base_r[i].base + DN_W'(CUM_DAYS[s3_base_r[i].month])
                   + DN_W'(s3_base_r[i].leap && (s3_base_r[i].month >= MARCH))
                   + DN_W'(s3_base_r[i].day);
    end
  end

  // stage 5: difference, zero without overlap, clamped at zero and at the field maximum
  always_comb begin
    logic [DN_W:0] diff;
    diff = {1'b0, s4_dn_r[1]} - {1'b0, s4_dn_r[0]};
    out_periods_overlap_nxt = s4_ov_r;
    priority if (!s4_ov_r || diff[DN_W]) begin
      out_overlap_days_nxt = '0;
    end else if (diff[DN_W-1:DAYS_W] != '0) begin
      out_overlap_days_nxt = DAYS_MAX;
    end else begin
      out_overlap_days_nxt = diff[DAYS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_date_r <= s1_date_nxt;
      s1_ov_r   <= s1_ov_nxt;
    end
    if (adv[1]) begin
      s2_part_r <= s2_part_nxt;
      s2_ov_r   <= s1_ov_r;
    end
    if (adv[2]) begin
      s3_base_r <= s3_base_nxt;
      s3_ov_r   <= s2_ov_r;
    end
    if (adv[3]) begin
      s4_dn_r <= s4_dn_nxt;
      s4_ov_r <= s3_ov_r;
    end
    if (adv[4]) begin
      out_periods_overlap_r <= out_periods_overlap_nxt;
      out_overlap_days_r    <= out_overlap_days_nxt;
    end
  end

  assign out_periods_overlap = out_periods_overlap_r;
  assign out_overlap_days    = out_overlap_days_r;

endmodule

[design/dpod_checker.sv]
// port-level checks for the date period overlap block, bound to the top level
module dpod_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [dpod_pkg::YEAR_W-1:0]   in_first_start_year,
  input logic [dpod_pkg::MONTH_W-1:0]  in_first_start_month,
  input logic [dpod_pkg::DAY_W-1:0]    in_first_start_day,
  input logic [dpod_pkg::YEAR_W-1:0]   in_first_end_year,
  input logic [dpod_pkg::MONTH_W-1:0]  in_first_end_month,
  input logic [dpod_pkg::DAY_W-1:0]    in_first_end_day,
  input logic [dpod_pkg::YEAR_W-1:0]   in_second_start_year,
  input logic [dpod_pkg::MONTH_W-1:0]  in_second_start_month,
  input logic [dpod_pkg::DAY_W-1:0]    in_second_start_day,
  input logic [dpod_pkg::YEAR_W-1:0]   in_second_end_year,
  input logic [dpod_pkg::MONTH_W-1:0]  in_second_end_month,
  input logic [dpod_pkg::DAY_W-1:0]    in_second_end_day,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_periods_overlap,
  input logic [dpod_pkg::DAYS_W-1:0]   out_overlap_days
);
  import dpod_pkg::*;
  `include "date_period_overlap_days_assert.svh"

  // a held result keeps its payload
  `DPOD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_periods_overlap) && $stable(out_overlap_days))

  // no overlap means no days
  `DPOD_ASSERT_NOW(a_no_overlap_zero, clk, rst_n, out_valid && !out_periods_overlap, out_overlap_days == '0)

  // input backs up only behind a blocked output
  `DPOD_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

bind date_period_overlap_days dpod_checker u_dpod_checker (.*);

[tb/tb_top.sv]
// testbench for the date period overlap day counter: directed and random requests, scoreboard
module tb_top;
  import dpod_pkg::*;

  typedef struct {
    date_t first_start;
    date_t first_end;
    date_t second_start;
    date_t second_end;
    bit    drain;  // hold this request until every result is back
  } period_pair_t;

  typedef struct {
    logic              hit;
    logic [DAYS_W-1:0] days;
  } overlap_t;

  localparam int MONTH_START [16] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
  };
  localparam int MONTH_LEN [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  date_t drv_fs = '0;
  date_t drv_fe = '0;
  date_t drv_ss = '0;
  date_t drv_se = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_periods_overlap;
  logic [DAYS_W-1:0] out_overlap_days;

  period_pair_t pending_requests [$];
  overlap_t expected_overlaps [$];
  period_pair_t in_flight;
  int in_gap = 0;
  int out_gap = 0;
  bit in_no_idle = 1'b0;
  bit out_no_idle = 1'b0;
  int errors = 0;

  date_period_overlap_days DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_first_start_year   (drv_fs.year),
    .in_first_start_month  (drv_fs.month),
    .in_first_start_day    (drv_fs.day),
    .in_first_end_year     (drv_fe.year),
    .in_first_end_month    (drv_fe.month),
    .in_first_end_day      (drv_fe.day),
    .in_second_start_year  (drv_ss.year),
    .in_second_start_month (drv_ss.month),
    .in_second_start_day   (drv_ss.day),
    .in_second_end_year    (drv_se.year),
    .in_second_end_month   (drv_se.month),
    .in_second_end_day     (drv_se.day),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_periods_overlap   (out_periods_overlap),
    .out_overlap_days      (out_overlap_days)
  );

  always #4 clk = ~clk;

  function automatic bit is_leap_year(longint y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // days from the start of year 0 (a leap year) through the given date
  function automatic longint date_serial(date_t d);
    longint y;
    longint n;
    y = longint'(d.year);
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + MONTH_START[d.month];
    if (d.month >= MARCH && is_leap_year(y))
      n++;
    return n + longint'(d.day);
  endfunction

  function automatic overlap_t predict_overlap(period_pair_t p);
    overlap_t o;
    date_t later_start;
    date_t earlier_end;
    longint span;
    // packed compare orders by year, then month, then day
    o.hit = !(p.first_end < p.second_start) && !(p.second_end < p.first_start);
    o.days = '0;
    if (o.hit) begin
      later_start = (p.first_start < p.second_start) ? p.second_start : p.first_start;
      earlier_end = (p.first_end < p.second_end) ? p.first_end : p.second_end;
      span = date_serial(earlier_end) - date_serial(later_start);
      if (span < 0)
        span = 0;
      if (span > longint'(DAYS_MAX))
        span = longint'(DAYS_MAX);
      o.days = span[DAYS_W-1:0];
    end
    return o;
  endfunction

  function automatic date_t mk_date(int y, int m, int d);
    date_t r;
    r.year = YEAR_W'(y);
    r.month = MONTH_W'(m);
    r.day = DAY_W'(d);
    return r;
  endfunction

  function automatic date_t rand_valid_date(int ylo, int yhi);
    int y;
    int m;
    int len;
    y = $urandom_range(yhi, ylo);
    m = $urandom_range(12, 1);
    len = MONTH_LEN[m] + ((m == 2 && is_leap_year(y)) ? 1 : 0);
    return mk_date(y, m, $urandom_range(len, 1));
  endfunction

  function automatic date_t rand_raw_date();
    return mk_date($urandom_range(16383, 0), $urandom_range(15, 0), $urandom_range(31, 0));
  endfunction

  task automatic add_pair(date_t fs, date_t fe, date_t ss, date_t se, bit drain);
    period_pair_t p;
    p.first_start = fs;
    p.first_end = fe;
    p.second_start = ss;
    p.second_end = se;
    p.drain = drain;
    pending_requests.push_back(p);
  endtask

  task automatic add_random_pair(bit drain);
    date_t d [4];
    date_t t;
    int mode;
    int base;
    mode = $urandom_range(99, 0);
    if (mode < 15) begin
      // noise over the full field ranges
      foreach (d[i]) d[i] = rand_raw_date();
    end else begin
      if (mode < 40) begin
        foreach (d[i]) d[i] = rand_valid_date(1, 9999);
      end else begin
        base = $urandom_range(9999, 1);
        foreach (d[i])
          d[i] = rand_valid_date((base > 2) ? base - 2 : 1, (base < 9997) ? base + 2 : 9999);
      end
      if (d[1] < d[0]) begin
        t = d[0]; d[0] = d[1]; d[1] = t;
      end
      if (d[3] < d[2]) begin
        t = d[2]; d[2] = d[3]; d[3] = t;
      end
      // shared boundary dates
      case ($urandom_range(7, 0))
        0: if (!(d[3] < d[1])) d[2] = d[1];
        1: if (!(d[1] < d[3])) d[0] = d[3];
        2: d[2] = d[0];
        default: ;
      endcase
    end
    add_pair(d[0], d[1], d[2], d[3], drain);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_overlaps.push_back(predict_overlap(in_flight));
        if ($urandom_range(99, 0) == 0)
          in_no_idle = !in_no_idle;
        in_gap = in_no_idle ? 0 : $urandom_range(3, 0);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].drain && expected_overlaps.size() > 0)) begin
          in_flight = pending_requests.pop_front();
          drv_fs <= in_flight.first_start;
          drv_fe <= in_flight.first_end;
          drv_ss <= in_flight.second_start;
          drv_se <= in_flight.second_end;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    overlap_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_overlaps.size() == 0) begin
          $display("%0t: result with no request pending, actual overlap %0d days %0d",
                   $time, out_periods_overlap, out_overlap_days);
          errors++;
        end else begin
          want = expected_overlaps.pop_front();
          if (out_periods_overlap !== want.hit) begin
            $display("%0t: periods_overlap expected %0d actual %0d",
                     $time, want.hit, out_periods_overlap);
            errors++;
          end
          if (out_overlap_days !== want.days) begin
            $display("%0t: overlap_days expected %0d actual %0d",
                     $time, want.days, out_overlap_days);
            errors++;
          end
        end
        if ($urandom_range(99, 0) == 0)
          out_no_idle = !out_no_idle;
        out_gap = out_no_idle ? 0 : $urandom_range(3, 0);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    // touching on one date, adjacent, disjoint both ways
    add_pair(mk_date(2020, 5, 5), mk_date(2020, 5, 5), mk_date(2020, 5, 5),
             mk_date(2020, 5, 5), 1'b0);
    add_pair(mk_date(2021, 1, 1), mk_date(2021, 3, 15), mk_date(2021, 3, 15),
             mk_date(2021, 9, 1), 1'b0);
    add_pair(mk_date(2021, 1, 1), mk_date(2021, 3, 14), mk_date(2021, 3, 15),
             mk_date(2021, 9, 1), 1'b0);
    add_pair(mk_date(1999, 7, 1), mk_date(2001, 1, 1), mk_date(1990, 1, 1),
             mk_date(1999, 6, 30), 1'b0);
    // widest legal periods and nesting
    add_pair(mk_date(1, 1, 1), mk_date(9999, 12, 31), mk_date(1, 1, 1),
             mk_date(9999, 12, 31), 1'b0);
    add_pair(mk_date(1, 1, 1), mk_date(9999, 12, 31), mk_date(1600, 2, 29),
             mk_date(2400, 3, 1), 1'b0);
    // century leap rules around february
    add_pair(mk_date(2000, 2, 28), mk_date(2000, 3, 1), mk_date(2000, 1, 1),
             mk_date(2000, 12, 31), 1'b0);
    add_pair(mk_date(1900, 2, 28), mk_date(1900, 3, 1), mk_date(1900, 1, 1),
             mk_date(1900, 12, 31), 1'b0);
    add_pair(mk_date(2100, 2, 1), mk_date(2100, 3, 1), mk_date(2004, 2, 1),
             mk_date(2104, 3, 1), 1'b0);
    // month zero, months above twelve, day zero, day past month end
    add_pair(mk_date(2010, 0, 0), mk_date(2010, 13, 31), mk_date(2010, 0, 5),
             mk_date(2010, 15, 31), 1'b0);
    add_pair(mk_date(2012, 2, 31), mk_date(2012, 14, 0), mk_date(2012, 1, 0),
             mk_date(2012, 12, 31), 1'b0);
    // nonexistent day pushes the later start past the earlier end
    add_pair(mk_date(2020, 2, 31), mk_date(2020, 3, 1), mk_date(2020, 1, 1),
             mk_date(2020, 3, 1), 1'b0);
    // start after its own end
    add_pair(mk_date(2020, 6, 10), mk_date(2020, 6, 1), mk_date(2020, 5, 5),
             mk_date(2020, 7, 20), 1'b0);
    add_pair(mk_date(2020, 6, 10), mk_date(2020, 6, 30), mk_date(2020, 6, 20),
             mk_date(2020, 6, 12), 1'b0);
    // saturation and field extremes
    add_pair(mk_date(0, 0, 0), mk_date(16383, 15, 31), mk_date(0, 0, 0),
             mk_date(16383, 15, 31), 1'b0);
    add_pair(mk_date(16383, 15, 31), mk_date(16383, 15, 31), mk_date(16383, 15, 31),
             mk_date(16383, 15, 31), 1'b0);
    add_pair(mk_date(0, 0, 0), mk_date(0, 0, 0), mk_date(0, 0, 0), mk_date(0, 0, 0), 1'b0);
    add_pair(mk_date(0, 1, 1), mk_date(11482, 1, 1), mk_date(0, 1, 1),
             mk_date(11483, 1, 1), 1'b0);
    add_pair(mk_date(10000, 1, 1), mk_date(16383, 12, 31), mk_date(9999, 12, 31),
             mk_date(16000, 6, 15), 1'b0);

    for (int i = 0; i < 1500; i++)
      add_random_pair(i == 0 || i == 600 || i == 1100);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_requests.size() > 0 || in_valid || expected_overlaps.size() > 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_overlaps.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
